### design/timestamp_coincidence_slot_store_assert.svh
// Assertion macros used by the slot store RTL.
`ifndef TIMESTAMP_COINCIDENCE_SLOT_STORE_ASSERT_SVH
`define TIMESTAMP_COINCIDENCE_SLOT_STORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define TCSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slot store assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define TCSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slot store assertion failed");

`endif

### design/tcss_pkg.sv
`default_nettype none
package tcss_pkg;
  localparam int DEPTH     = 1024;
  localparam int N_TYPES   = 6;
  localparam int SLOT_W    = 10;
  localparam int CNT_W     = 11;
  localparam int TYPE_W    = 3;
  localparam int TS_W      = 64;
  localparam int CFG_W     = 32;
  localparam int MEM_DEPTH = N_TYPES * DEPTH;
  localparam int ADDR_W    = TYPE_W + SLOT_W;
  localparam int TIDX_W    = $clog2(N_TYPES);
  localparam logic [CFG_W-1:0] WIDTH_RESET = 32'd50000;

  typedef enum logic [1:0] {
    FUNC_STORE  = 2'd0,
    FUNC_PURGE  = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_OFFSET = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_ST_A,
    S_ST_B,
    S_PG_A,
    S_SR
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  idx;
    logic [TS_W-1:0]   value;
  } cell_data_t;
endpackage
`default_nettype wire

### design/tcss_ram.sv
`default_nettype none
module tcss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### design/tcss_cell.sv
`default_nettype none
module tcss_cell import tcss_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            flush_i,
  input  wire cell_data_t      in_i,
  input  wire logic [TS_W-1:0] operand_i,
  output cell_data_t           out_o
);
  logic             valid_q;
  logic [CNT_W-1:0] idx_q;
  logic [TS_W-1:0]  value_q;
  logic [TS_W-1:0]  diff;

  assign diff = (in_i.value > operand_i) ? (in_i.value - operand_i)
                                         : (operand_i - in_i.value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid && !flush_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= in_i.idx;
    value_q <= diff;
  end

  assign out_o = '{valid: valid_q, idx: idx_q, value: value_q};
endmodule
`default_nettype wire

### design/timestamp_coincidence_slot_store.sv
`default_nettype none
// Slot store for event timestamps, one table of 1024 slots for each of six detector types.
// A command is taken when start_i is high and busy_o is low, and exactly one result follows,
// shown for one cycle with done_o high; the receiver cannot stall, so it must take the result
// in that cycle. Store uses the next unused slot when the free list is empty and else pops one;
// purge reads the occupied bit and clears it; search reads one slot per cycle from the timestamp
// memory and then two compare cells. After reset the block clears the occupied bits, one slot
// per cycle, and stays busy until all are clear; configuration writes are taken at any time.
module timestamp_coincidence_slot_store import tcss_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [1:0]          func_i,
  input  wire logic [TYPE_W-1:0]   det_type_i,
  input  wire logic [TS_W-1:0]     timestamp_i,
  input  wire logic [SLOT_W-1:0]   slot_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  output logic                     done_o,
  output logic [SLOT_W-1:0]        slot_index_o,
  output logic                     found_o,
  output logic [1:0]               status_o
);
  `include "timestamp_coincidence_slot_store_assert.svh"

  state_e              state_q, state_d;
  logic [1:0]          func_q;
  logic [TYPE_W-1:0]   type_q;
  logic [TS_W-1:0]     ts_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   val_q, val_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [ADDR_W-1:0]   clr_q;
  logic [CFG_W-1:0]    width_q, offset_q;
  logic [CNT_W-1:0]    fc_q [N_TYPES];
  logic [CNT_W-1:0]    uc_q [N_TYPES];
  logic [CNT_W-1:0]    fc_d [N_TYPES];
  logic [CNT_W-1:0]    uc_d [N_TYPES];
  logic                rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0]    rd_idx_q;

  logic                type_ok;
  logic [TIDX_W-1:0]   tidx;
  logic [CNT_W-1:0]    fc_cur, uc_cur;

  logic                sm_we;
  logic [ADDR_W-1:0]   sm_waddr, sm_raddr;
  logic [TS_W:0]       sm_wdata, sm_rdata;
  logic                fs_we;
  logic [ADDR_W-1:0]   fs_waddr, fs_raddr;
  logic [SLOT_W-1:0]   fs_wdata, fs_rdata;

  cell_data_t          c0_in, c0_out, c1_out;
  logic                flush, match, inflight;

  logic                res_vld_d;
  logic [SLOT_W-1:0]   res_idx_d;
  logic                res_fnd_d;
  logic [1:0]          res_st_d;

  assign type_ok = (type_q < TYPE_W'(N_TYPES));
  assign tidx    = type_ok ? type_q[TIDX_W-1:0] : '0;
  assign fc_cur  = type_ok ? fc_q[tidx] : '0;
  assign uc_cur  = type_ok ? uc_q[tidx] : '0;

  tcss_ram #(.Width(TS_W + 1), .Depth(MEM_DEPTH)) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .raddr_i (sm_raddr),
    .rdata_o (sm_rdata)
  );

  tcss_ram #(.Width(SLOT_W), .Depth(MEM_DEPTH)) u_free_mem (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  assign flush = (state_q != S_SR);
  assign c0_in = '{valid: rd_vld_q && sm_rdata[TS_W] && !flush, idx: rd_idx_q, value: ts_q};

  tcss_cell u_cell_diff (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .flush_i   (flush),
    .in_i      (c0_in),
    .operand_i (sm_rdata[TS_W-1:0]),
    .out_o     (c0_out)
  );

  tcss_cell u_cell_offset (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .flush_i   (flush),
    .in_i      (c0_out),
    .operand_i ({{(TS_W-CFG_W){1'b0}}, offset_q}),
    .out_o     (c1_out)
  );

  assign match    = c1_out.valid && (c1_out.value < {{(TS_W-CFG_W){1'b0}}, width_q});
  assign inflight = rd_vld_q || c0_out.valid || c1_out.valid;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == ADDR_W'(MEM_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        if (type_ok) begin
          case (func_q)
            FUNC_STORE:  if (fc_cur != '0) state_d = S_ST_A;
            FUNC_PURGE:  state_d = S_PG_A;
            FUNC_SEARCH: state_d = S_SR;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_ST_A: state_d = S_ST_B;
      S_ST_B: state_d = S_IDLE;
      S_PG_A: state_d = S_IDLE;
      S_SR: begin
        if (match || (idx_q >= uc_cur && !inflight)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    fc_d      = fc_q;
    uc_d      = uc_q;
    val_d     = val_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    sm_we     = 1'b0;
    sm_waddr  = {type_q, slot_q};
    sm_wdata  = '0;
    sm_raddr  = {type_q, slot_q};
    fs_we     = 1'b0;
    fs_waddr  = {type_q, {SLOT_W{1'b0}}};
    fs_wdata  = fs_rdata;
    fs_raddr  = {type_q, {SLOT_W{1'b0}}};
    res_vld_d = 1'b0;
    res_idx_d = '0;
    res_fnd_d = 1'b0;
    res_st_d  = STATUS_OK;
    unique case (state_q)
      S_CLEAR: begin
        sm_we    = 1'b1;
        sm_waddr = clr_q;
      end
      S_DISPATCH: begin
        idx_d = '0;
        if (func_q == FUNC_NONE) begin
          res_vld_d = 1'b1;
        end else if (!type_ok) begin
          res_vld_d = 1'b1;
          if (func_q == FUNC_STORE) res_st_d = STATUS_FULL;
          if (func_q == FUNC_PURGE) res_st_d = STATUS_EMPTY;
        end else if (func_q == FUNC_STORE && fc_cur == '0) begin
          res_vld_d = 1'b1;
          if (uc_cur < CNT_W'(DEPTH)) begin
            uc_d[tidx] = uc_cur + CNT_W'(1);
            sm_we      = 1'b1;
            sm_waddr   = {type_q, uc_cur[SLOT_W-1:0]};
            sm_wdata   = {1'b1, ts_q};
            res_idx_d  = uc_cur[SLOT_W-1:0];
          end else begin
            res_st_d = STATUS_FULL;
          end
        end
      end
      S_ST_A: begin
        val_d    = fs_rdata;
        fs_raddr = {type_q, SLOT_W'(fc_cur - CNT_W'(1))};
      end
      S_ST_B: begin
        fs_we      = 1'b1;
        fc_d[tidx] = fc_cur - CNT_W'(1);
        sm_we      = 1'b1;
        sm_waddr   = {type_q, val_q};
        sm_wdata   = {1'b1, ts_q};
        res_vld_d  = 1'b1;
        res_idx_d  = val_q;
      end
      S_PG_A: begin
        res_vld_d = 1'b1;
        if (!sm_rdata[TS_W]) begin
          res_st_d = STATUS_EMPTY;
        end else begin
          sm_we = 1'b1;
          if (({1'b0, slot_q} + CNT_W'(1)) < uc_cur) begin
            if (fc_cur < CNT_W'(DEPTH)) begin
              fs_we      = 1'b1;
              fs_waddr   = {type_q, fc_cur[SLOT_W-1:0]};
              fs_wdata   = slot_q;
              fc_d[tidx] = fc_cur + CNT_W'(1);
            end
          end else if (uc_cur != '0) begin
            uc_d[tidx] = uc_cur - CNT_W'(1);
          end
        end
      end
      S_SR: begin
        sm_raddr = {type_q, idx_q[SLOT_W-1:0]};
        if (match) begin
          res_vld_d = 1'b1;
          res_fnd_d = 1'b1;
          res_idx_d = c1_out.idx[SLOT_W-1:0];
        end else if (idx_q < uc_cur) begin
          rd_vld_d = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
        end else if (!inflight) begin
          res_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      width_q  <= WIDTH_RESET;
      offset_q <= '0;
      rd_vld_q <= 1'b0;
      done_o   <= 1'b0;
      for (int k = 0; k < N_TYPES; k++) begin
        fc_q[k] <= '0;
        uc_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      done_o   <= res_vld_d;
      fc_q     <= fc_d;
      uc_q     <= uc_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_WIDTH) width_q <= cfg_data_i;
        else offset_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      func_q <= func_i;
      type_q <= det_type_i;
      ts_q   <= timestamp_i;
      slot_q <= slot_i;
    end
    val_q        <= val_d;
    idx_q        <= idx_d;
    rd_idx_q     <= idx_q;
    slot_index_o <= res_idx_d;
    found_o      <= res_fnd_d;
    status_o     <= res_st_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  `TCSS_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `TCSS_ASSERT_NOW(a_found_ok, done_o && found_o, status_o == STATUS_OK)
  `TCSS_ASSERT_NOW(a_counts_bounded, type_ok, fc_cur <= CNT_W'(DEPTH) && uc_cur <= CNT_W'(DEPTH))
  `TCSS_ASSERT_NEXT(a_one_result, done_o, !done_o)
endmodule
`default_nettype wire

### bench/tb_timestamp_coincidence_slot_store.sv
`default_nettype none
module tb_timestamp_coincidence_slot_store;
  import tcss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]        func;
    logic [TYPE_W-1:0] det_type;
    logic [TS_W-1:0]   ts;
    logic [SLOT_W-1:0] slot;
  } command_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              found;
    logic [1:0]        status;
  } outcome_t;

  class slot_store_scoreboard;
    logic [TS_W-1:0]   ts_mem[N_TYPES][DEPTH];
    bit                occ[N_TYPES][DEPTH];
    logic [SLOT_W-1:0] free_list[N_TYPES][DEPTH];
    int unsigned       free_cnt[N_TYPES];
    int unsigned       used_cnt[N_TYPES];
    logic [CFG_W-1:0]  win_width;
    logic [CFG_W-1:0]  win_offset;
    outcome_t          pending[$];
    int                errors;

    function new();
      win_width  = WIDTH_RESET;
      win_offset = '0;
      errors     = 0;
      for (int t = 0; t < N_TYPES; t++) begin
        free_cnt[t] = 0;
        used_cnt[t] = 0;
        for (int i = 0; i < DEPTH; i++) occ[t][i] = 0;
      end
    endfunction

    function bit in_window(logic [TS_W-1:0] a, logic [TS_W-1:0] b);
      logic [TS_W-1:0] d;
      logic [TS_W-1:0] e;
      logic [TS_W-1:0] off;
      off = {32'd0, win_offset};
      d = (a > b) ? a - b : b - a;
      e = (d >= off) ? d - off : off - d;
      return e < {32'd0, win_width};
    endfunction

    function void note(command_t c);
      outcome_t    r;
      int          t;
      int unsigned v;
      int unsigned fc;
      r = '0;
      t = c.det_type;
      if (func_e'(c.func) == FUNC_NONE) begin
        r = '0;
      end else if (t >= N_TYPES) begin
        if (func_e'(c.func) == FUNC_STORE) r.status = STATUS_FULL;
        else if (func_e'(c.func) == FUNC_PURGE) r.status = STATUS_EMPTY;
      end else begin
        case (func_e'(c.func))
          FUNC_STORE: begin
            fc = free_cnt[t];
            v = DEPTH;
            if (fc > 0) begin
              v = free_list[t][0];
              free_list[t][0] = free_list[t][fc-1];
              free_cnt[t] = fc - 1;
            end else if (used_cnt[t] < DEPTH) begin
              v = used_cnt[t];
              used_cnt[t] = v + 1;
            end
            if (v == DEPTH) begin
              r.status = STATUS_FULL;
            end else begin
              ts_mem[t][v] = c.ts;
              occ[t][v] = 1;
              r.slot_index = v[SLOT_W-1:0];
            end
          end
          FUNC_PURGE: begin
            if (!occ[t][c.slot]) begin
              r.status = STATUS_EMPTY;
            end else begin
              occ[t][c.slot] = 0;
              if (int'(c.slot) + 1 < used_cnt[t]) begin
                if (free_cnt[t] < DEPTH) begin
                  free_list[t][free_cnt[t]] = c.slot;
                  free_cnt[t]++;
                end
              end else if (used_cnt[t] > 0) begin
                used_cnt[t]--;
              end
            end
          end
          default: begin
            for (int i = 0; i < used_cnt[t]; i++) begin
              if (occ[t][i] && in_window(c.ts, ts_mem[t][i])) begin
                r.slot_index = i[SLOT_W-1:0];
                r.found = 1'b1;
                break;
              end
            end
          end
        endcase
      end
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        report("result with no command outstanding");
      end else begin
        want = pending.pop_front();
        if (got.slot_index !== want.slot_index)
          report($sformatf("slot_index %0d, expected %0d", got.slot_index, want.slot_index));
        if (got.found !== want.found)
          report($sformatf("found %0b, expected %0b", got.found, want.found));
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [1:0]        func_i = '0;
  logic [TYPE_W-1:0] det_type_i = '0;
  logic [TS_W-1:0]   timestamp_i = '0;
  logic [SLOT_W-1:0] slot_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_index_i = 1'b0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              busy_o;
  logic              cfg_ready_o;
  logic              done_o;
  logic [SLOT_W-1:0] slot_index_o;
  logic              found_o;
  logic [1:0]        status_o;

  slot_store_scoreboard sb = new();
  int                   idle_cycles = 0;
  logic [TS_W-1:0]      anchors[4];

  timestamp_coincidence_slot_store DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check('{slot_index_o, found_o, status_o});
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic issue(command_t c);
    @(negedge clk_i);
    start_i     = 1'b1;
    func_i      = c.func;
    det_type_i  = c.det_type;
    timestamp_i = c.ts;
    slot_i      = c.slot;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    sb.note(c);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    pause_sender(0);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    if (idx == CFG_WIDTH) sb.win_width = value;
    else sb.win_offset = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic command_t mk(func_e f, int t, logic [TS_W-1:0] ts, int s);
    command_t c;
    c.func = f;
    c.det_type = t[TYPE_W-1:0];
    c.ts = ts;
    c.slot = s[SLOT_W-1:0];
    return c;
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    logic [TS_W-1:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) r = anchors[$urandom_range(0, 3)] + $urandom_range(0, 300000);
    return r;
  endfunction

  function automatic int pick_occupied(int t);
    int i;
    for (int k = 0; k < 12; k++) begin
      if (sb.used_cnt[t] == 0) break;
      i = $urandom_range(0, sb.used_cnt[t] - 1);
      if (sb.occ[t][i]) return i;
    end
    return $urandom_range(0, DEPTH - 1);
  endfunction

  function automatic command_t rand_cmd(int t);
    int              p;
    int              s;
    longint unsigned lim;
    logic [TS_W-1:0] ts;
    p = $urandom_range(0, 99);
    ts = rand_ts();
    if (p < 40) return mk(FUNC_STORE, t, ts, $urandom_range(0, DEPTH - 1));
    if (p < 68) begin
      if ($urandom_range(0, 4) == 0) s = $urandom_range(0, DEPTH - 1);
      else if ($urandom_range(0, 3) == 0 && sb.used_cnt[t] > 0) s = sb.used_cnt[t] - 1;
      else s = pick_occupied(t);
      return mk(FUNC_PURGE, t, ts, s);
    end
    if (p < 95) begin
      s = pick_occupied(t);
      if (sb.occ[t][s] && $urandom_range(0, 9) < 7) begin
        lim = longint'(sb.win_width) + longint'(sb.win_offset) + 4;
        if (lim > 32'hFFFF_FFFF) lim = 32'hFFFF_FFFF;
        ts = sb.ts_mem[t][s];
        if ($urandom_range(0, 1)) ts = ts + $urandom_range(0, int'(lim[31:0]));
        else ts = ts - $urandom_range(0, int'(lim[31:0]));
      end
      return mk(FUNC_SEARCH, t, ts, $urandom_range(0, DEPTH - 1));
    end
    if (p < 98) return mk(func_e'($urandom_range(0, 2)), $urandom_range(N_TYPES, 7), ts,
                          $urandom_range(0, DEPTH - 1));
    return mk(FUNC_NONE, $urandom_range(0, 7), ts, $urandom_range(0, DEPTH - 1));
  endfunction

  task automatic random_phase(int n, int t_hi);
    int left;
    int burst;
    int gap;
    left = n;
    for (int k = 0; k < 4; k++) anchors[k] = {$urandom, $urandom};
    anchors[0] = '0;
    anchors[1] = {TS_W{1'b1}} - 64'd300000;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && left > 0; k++, left--)
        issue(rand_cmd($urandom_range(0, t_hi)));
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap != 0) pause_sender(gap);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    issue(mk(FUNC_STORE, 0, 64'd0, 0));
    issue(mk(FUNC_STORE, 0, {TS_W{1'b1}}, 0));
    issue(mk(FUNC_STORE, 0, 64'd100, 0));
    issue(mk(FUNC_STORE, 0, 64'h8000_0000_0000_0000, 0));
    issue(mk(FUNC_SEARCH, 0, 64'd60000, 0));
    issue(mk(FUNC_SEARCH, 0, {TS_W{1'b1}} - 64'd49999, 0));
    issue(mk(FUNC_SEARCH, 0, 64'd40000, 0));
    issue(mk(FUNC_PURGE, 0, '0, 0));
    issue(mk(FUNC_PURGE, 0, '0, 0));
    issue(mk(FUNC_SEARCH, 0, 64'd0, 0));
    issue(mk(FUNC_STORE, 0, 64'd7, 0));
    issue(mk(FUNC_PURGE, 0, '0, 3));
    issue(mk(FUNC_PURGE, 0, '0, 1023));
    issue(mk(FUNC_SEARCH, 1, 64'd5, 0));
    issue(mk(FUNC_STORE, 6, 64'd5, 0));
    issue(mk(FUNC_PURGE, 7, 64'd5, 0));
    issue(mk(FUNC_SEARCH, 6, 64'd5, 0));
    issue(mk(FUNC_NONE, 0, {TS_W{1'b1}}, 1023));
    drain();
    write_reg(CFG_WIDTH, '0);
    issue(mk(FUNC_SEARCH, 0, 64'd7, 0));
    drain();
    write_reg(CFG_WIDTH, {CFG_W{1'b1}});
    write_reg(CFG_OFFSET, {CFG_W{1'b1}});
    issue(mk(FUNC_SEARCH, 0, 64'hFFFF_FFFF, 0));
    issue(mk(FUNC_SEARCH, 0, 64'h1_0000_0007, 0));
    drain();

    write_reg(CFG_WIDTH, $urandom_range(1000, 100000));
    write_reg(CFG_OFFSET, $urandom_range(0, 50000));
    random_phase(140, 4);
    drain();
    write_reg(CFG_WIDTH, 32'h0000_FFFF);
    write_reg(CFG_OFFSET, '0);
    random_phase(140, 4);
    drain();
    write_reg(CFG_WIDTH, {CFG_W{1'b1}});
    write_reg(CFG_OFFSET, {CFG_W{1'b1}});
    random_phase(110, 4);
    drain();
    write_reg(CFG_WIDTH, $urandom);
    write_reg(CFG_OFFSET, $urandom);
    random_phase(110, 4);
    drain();

    write_reg(CFG_WIDTH, 32'd10);
    write_reg(CFG_OFFSET, '0);
    for (int k = 0; k < 40; k++) issue(mk(FUNC_STORE, 5, {$urandom, $urandom}, 0));
    issue(mk(FUNC_SEARCH, 5, sb.ts_mem[5][39], 0));
    issue(mk(FUNC_PURGE, 5, '0, 17));
    issue(mk(FUNC_PURGE, 5, '0, 39));
    issue(mk(FUNC_STORE, 5, 64'd123, 0));
    issue(mk(FUNC_STORE, 5, 64'd456, 0));
    issue(mk(FUNC_STORE, 5, 64'd789, 0));
    issue(mk(FUNC_SEARCH, 5, 64'd450, 0));
    issue(mk(FUNC_SEARCH, 5, 64'd1, 0));
    drain();
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

### timestamp_coincidence_slot_store.f
+incdir+design
design/tcss_pkg.sv
design/tcss_ram.sv
design/tcss_cell.sv
design/timestamp_coincidence_slot_store.sv
bench/tb_timestamp_coincidence_slot_store.sv
